// ===== sv/fsla_pkg.sv =====
// ----------------------------------------------------------------------------
// fsla_pkg: shared types and constants of the slot pool allocator
// Command and status codes, result type, controller states, pool limits.
// ----------------------------------------------------------------------------
package fsla_pkg;

   localparam int POOL_SLOTS = 256;
   localparam int SLOT_W     = 8;
   localparam int SIZE_W     = 9;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int LINK_W     = SLOT_W + 1;
   localparam int POOL_LIMIT = (POOL_SLOTS < (1 << SLOT_W)) ? POOL_SLOTS : (1 << SLOT_W);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1 << SLOT_W);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(POOL_LIMIT);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(1);

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   granted_slot;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

endpackage

// ===== sv/fsla_link_ram.sv =====
// ----------------------------------------------------------------------------
// fsla_link_ram: single-port-write, single-port-read link memory
// Synchronous write, registered read data.
// ----------------------------------------------------------------------------
module fsla_link_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fsla_out_queue.sv =====
// ----------------------------------------------------------------------------
// fsla_out_queue: two-entry result queue
// Decouples the response channel so a new request is taken while a result waits.
// ----------------------------------------------------------------------------
module fsla_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fsla_pkg::rsp_type push_data,
   output logic             space,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output fsla_pkg::rsp_type rsp_data
);

   fsla_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign space      = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/fsla_csr.sv =====
// ----------------------------------------------------------------------------
// fsla_csr: configuration register block
// Holds the pool size register and presents it clamped to the built depth.
// ----------------------------------------------------------------------------
module fsla_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output logic [fsla_pkg::SIZE_W-1:0]   pool_size
);

   logic [fsla_pkg::SIZE_W-1:0] slots_in_use_ff, slots_in_use_in;
   logic                        sel_size;
   logic                        wr_en;

   assign csr_pready = 1'b1;
   assign sel_size   = (csr_paddr[2] == 1'b0);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready && sel_size;

   always_comb begin
      slots_in_use_in = wr_en ? csr_pwdata[fsla_pkg::SIZE_W-1:0] : slots_in_use_ff;
      csr_prdata      = sel_size ? {{(32 - fsla_pkg::SIZE_W){1'b0}}, slots_in_use_ff} : 32'd0;
      if (slots_in_use_ff < fsla_pkg::SIZE_MIN) begin
         pool_size = fsla_pkg::SIZE_MIN;
      end else if (slots_in_use_ff > fsla_pkg::SIZE_MAX) begin
         pool_size = fsla_pkg::SIZE_MAX;
      end else begin
         pool_size = slots_in_use_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= fsla_pkg::SIZE_RESET;
      end else begin
         slots_in_use_ff <= slots_in_use_in;
      end
   end

endmodule

// ===== sv/fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator: fixed-slot pool allocator with LIFO free list
// Grants and takes back slot indices; freed slots chain through a link memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_tuser carries the command (allocate, free, reset pool),
//   req_tdata the slot index of a free. rsp channel: one result per request,
//   rsp_tdata the granted slot, rsp_tuser the status.
//   Allocate pops the free-list head, else the next never-granted slot, else
//   reports empty. Free pushes the slot if it lies below the pool size.
//   Pool size is set through the csr port at byte address 0.
// Timing:
//   A result is queued at the edge that accepts its request and is offered on
//   rsp once any results queued ahead of it are taken. Requests are taken one
//   per cycle while the result queue has space, except an allocate served from
//   the free list, which holds req_tready low in ST_POP while the link memory
//   read of the head entry returns the new head.
// Reset:
//   Clears the list and watermark at once; no memory sweep. The pool size
//   register returns to 256.
// Stall:
//   A two-entry result queue absorbs rsp stalls; req_tready drops when it is
//   full and during the head refill cycle.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] slot_index
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] granted_slot
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   fsla_pkg::state_type state_ff, state_in;

   logic [fsla_pkg::SLOT_W-1:0] head_ff, head_in;
   logic                        nonempty_ff, nonempty_in;
   logic [fsla_pkg::SIZE_W-1:0] fresh_ff, fresh_in;

   logic [fsla_pkg::SIZE_W-1:0] pool_size;
   logic                        q_space;
   logic                        req_fire;
   logic                        pop_start;
   logic [fsla_pkg::CMD_W-1:0]  cmd;
   logic [fsla_pkg::SLOT_W-1:0] idx;

   logic                        ram_wr_en;
   logic [fsla_pkg::LINK_W-1:0] ram_wr_data;
   logic [fsla_pkg::LINK_W-1:0] ram_rd_data;

   fsla_pkg::rsp_type result;
   fsla_pkg::rsp_type rsp_data;

   assign cmd        = req_tuser;
   assign idx        = req_tdata;
   assign req_tready = (state_ff == fsla_pkg::ST_IDLE) && q_space;
   assign req_fire   = req_tvalid && req_tready;
   assign pop_start  = req_fire && (cmd == fsla_pkg::CMD_ALLOC) && nonempty_ff;

   fsla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pool_size   (pool_size)
   );

   fsla_link_ram #(
      .DEPTH (fsla_pkg::POOL_SLOTS),
      .WIDTH (fsla_pkg::LINK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx),
      .wr_data (ram_wr_data),
      .rd_en   (pop_start),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   fsla_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (result),
      .space      (q_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = rsp_data.granted_slot;
   assign rsp_tuser = rsp_data.status;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsla_pkg::ST_IDLE: begin
            if (pop_start) begin
               state_in = fsla_pkg::ST_POP;
            end
         end
         fsla_pkg::ST_POP: begin
            state_in = fsla_pkg::ST_IDLE;
         end
         default: begin
            state_in = fsla_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in             = head_ff;
      nonempty_in         = nonempty_ff;
      fresh_in            = fresh_ff;
      ram_wr_en           = 1'b0;
      ram_wr_data         = {~nonempty_ff, head_ff};
      result.granted_slot = '0;
      result.status       = fsla_pkg::STATUS_OK;
      if (state_ff == fsla_pkg::ST_POP) begin
         // advance head from the link read
         if (ram_rd_data[fsla_pkg::SLOT_W]) begin
            nonempty_in = 1'b0;
         end else begin
            head_in = ram_rd_data[fsla_pkg::SLOT_W-1:0];
         end
      end else if (req_fire) begin
         case (cmd)
            fsla_pkg::CMD_ALLOC: begin
               if (nonempty_ff) begin
                  result.granted_slot = head_ff;
               end else if (fresh_ff < pool_size) begin
                  result.granted_slot = fresh_ff[fsla_pkg::SLOT_W-1:0];
                  fresh_in            = fresh_ff + fsla_pkg::SIZE_W'(1);
               end else begin
                  result.status = fsla_pkg::STATUS_EMPTY;
               end
            end
            fsla_pkg::CMD_FREE: begin
               if ({1'b0, idx} >= pool_size) begin
                  result.status = fsla_pkg::STATUS_RANGE;
               end else begin
                  ram_wr_en   = 1'b1;
                  head_in     = idx;
                  nonempty_in = 1'b1;
               end
            end
            fsla_pkg::CMD_RESET: begin
               head_in     = '0;
               nonempty_in = 1'b0;
               fresh_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fsla_pkg::ST_IDLE;
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         fresh_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         fresh_ff    <= fresh_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pop_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == fsla_pkg::ST_POP |-> !req_tready)
      else $error("request taken during head refill");

   a_pop_follows_alloc: assert property (@(posedge clock) disable iff (reset)
      pop_start |=> state_ff == fsla_pkg::ST_POP)
      else $error("list allocate did not refill head");

   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == fsla_pkg::ST_POP |=> state_ff == fsla_pkg::ST_IDLE)
      else $error("head refill longer than one cycle");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= fsla_pkg::SIZE_MAX)
      else $error("fresh watermark beyond pool depth");
`endif

endmodule

// ===== tb/fixed_slot_free_list_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_test: self-checking bench for the slot pool
// Drives allocate, free, reset-pool and unused commands with bursty pacing and
// a stalling result side, and tracks the free list, the fresh-slot watermark
// and the pool size alongside the block. Each result is checked in order
// against the grant and status tracked for its request.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_test;

   localparam logic [fsla_pkg::CMD_W-1:0] CMD_UNUSED       = 2'd3;
   localparam logic [2:0]                 REG_SLOTS_IN_USE = 3'd0;
   localparam int                         IDLE_LIMIT       = 2000;
   localparam int                         HOLD_CYCLES      = 100;

   class slot_pool_scoreboard;
      logic [fsla_pkg::SIZE_W-1:0] pool_size_reg;
      logic [fsla_pkg::SLOT_W-1:0] next_link [fsla_pkg::POOL_SLOTS];
      bit                          link_end  [fsla_pkg::POOL_SLOTS];
      logic [fsla_pkg::SLOT_W-1:0] list_head;
      bit                          list_nonempty;
      logic [fsla_pkg::SIZE_W-1:0] fresh_mark;
      fsla_pkg::rsp_type           expected_grants[$];
      logic [fsla_pkg::SLOT_W-1:0] held_slots[$];
      int                          errors;

      function new();
         pool_size_reg = fsla_pkg::SIZE_RESET;
         foreach (link_end[i]) begin
            link_end[i]  = 1'b0;
            next_link[i] = '0;
         end
         list_head     = '0;
         list_nonempty = 1'b0;
         fresh_mark    = '0;
         errors        = 0;
      endfunction

      function int effective_size();
         int n;
         n = pool_size_reg;
         if (n > fsla_pkg::POOL_LIMIT) n = fsla_pkg::POOL_LIMIT;
         if (n < 1) n = 1;
         return n;
      endfunction

      function void note_request(logic [fsla_pkg::CMD_W-1:0] cmd,
                                 logic [fsla_pkg::SLOT_W-1:0] idx);
         fsla_pkg::rsp_type r;
         int                size;
         int                hit;
         size           = effective_size();
         r.granted_slot = '0;
         r.status       = fsla_pkg::STATUS_OK;
         case (cmd)
            fsla_pkg::CMD_ALLOC: begin
               if (list_nonempty && list_head < fsla_pkg::POOL_SLOTS) begin
                  r.granted_slot = list_head;
                  if (link_end[list_head]) list_nonempty = 1'b0;
                  else list_head = next_link[list_head];
               end else if (fresh_mark < size) begin
                  r.granted_slot = fresh_mark[fsla_pkg::SLOT_W-1:0];
                  fresh_mark     = fresh_mark + 1'b1;
               end else begin
                  r.status = fsla_pkg::STATUS_EMPTY;
               end
               if (r.status == fsla_pkg::STATUS_OK) held_slots.push_back(r.granted_slot);
            end
            fsla_pkg::CMD_FREE: begin
               if (idx >= size) begin
                  r.status = fsla_pkg::STATUS_RANGE;
               end else begin
                  next_link[idx] = list_head;
                  link_end[idx]  = !list_nonempty;
                  list_head      = idx;
                  list_nonempty  = 1'b1;
                  hit = -1;
                  foreach (held_slots[j])
                     if (hit < 0 && held_slots[j] == idx) hit = j;
                  if (hit >= 0) held_slots.delete(hit);
               end
            end
            fsla_pkg::CMD_RESET: begin
               list_head     = '0;
               list_nonempty = 1'b0;
               fresh_mark    = '0;
               held_slots.delete();
            end
            default: ;
         endcase
         expected_grants.push_back(r);
      endfunction

      function void check_result(logic [fsla_pkg::SLOT_W-1:0] slot,
                                 logic [fsla_pkg::STATUS_W-1:0] status);
         fsla_pkg::rsp_type exp;
         if (expected_grants.size() == 0) begin
            $error("result with no request pending: granted_slot %0d status %0d",
                   slot, status);
            errors++;
            return;
         end
         exp = expected_grants.pop_front();
         if (slot !== exp.granted_slot) begin
            $error("granted_slot mismatch: expected %0d, actual %0d", exp.granted_slot, slot);
            errors++;
         end
         if (status !== exp.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp.status, status);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] slot_index
   logic [1:0]  req_tuser;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] granted_slot
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   slot_pool_scoreboard pool_tracker;
   bit                  hold_off_request;
   bit                  pacing_on;
   int                  burst_left;
   int                  idle_cycles;
   int                  csr_errors;

   fixed_slot_free_list_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         pool_tracker.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : rsp_pacer
      int mode;
      int stretch;
      rsp_tready = 1'b0;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(8, 60);
         for (int k = 0; k < stretch; k++) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= k[0];
            endcase
         end
      end
   end

   task automatic send_request(logic [fsla_pkg::CMD_W-1:0] cmd,
                               logic [fsla_pkg::SLOT_W-1:0] idx);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= idx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pool_tracker.note_request(cmd, idx);
   endtask

   task automatic paced_send(logic [fsla_pkg::CMD_W-1:0] cmd,
                             logic [fsla_pkg::SLOT_W-1:0] idx);
      if (burst_left == 0) begin
         if (pacing_on && $urandom_range(0, 1)) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_request(cmd, idx);
   endtask

   task automatic drain_results();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pool_tracker.expected_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pool_size(logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_SLOTS_IN_USE;
      csr_pwdata  <= value;
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      pool_tracker.pool_size_reg = value[fsla_pkg::SIZE_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_paddr   <= REG_SLOTS_IN_USE;
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {23'd0, value[fsla_pkg::SIZE_W-1:0]}) begin
         $error("slots_in_use mismatch: expected %0d, actual %0d",
                value[fsla_pkg::SIZE_W-1:0], csr_prdata);
         csr_errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_request(int alloc_pct);
      int                          roll;
      int                          size;
      logic [31:0]                 rnd;
      logic [fsla_pkg::CMD_W-1:0]  cmd;
      logic [fsla_pkg::SLOT_W-1:0] idx;
      roll = $urandom_range(0, 99);
      size = pool_tracker.effective_size();
      rnd  = $urandom;
      idx  = rnd[fsla_pkg::SLOT_W-1:0];
      cmd  = fsla_pkg::CMD_ALLOC;
      if (roll >= alloc_pct && roll < 93) begin
         if (pool_tracker.held_slots.size() != 0) begin
            cmd = fsla_pkg::CMD_FREE;
            idx = pool_tracker.held_slots[$urandom_range(0,
                     pool_tracker.held_slots.size() - 1)];
         end
      end else if (roll >= 93 && roll < 96) begin
         cmd = fsla_pkg::CMD_FREE;
      end else if (roll == 96) begin
         cmd = fsla_pkg::CMD_FREE;
         idx = (size >= 256) ? 8'd255 : size[fsla_pkg::SLOT_W-1:0];
      end else if (roll == 97) begin
         cmd = fsla_pkg::CMD_RESET;
      end else if (roll >= 98) begin
         cmd = CMD_UNUSED;
      end
      paced_send(cmd, idx);
   endtask

   task automatic run_phase(logic [31:0] size_value, bit clear_first, int count,
                            int alloc_pct, bit paced);
      logic [31:0] rnd;
      drain_results();
      write_pool_size(size_value);
      pacing_on        = paced;
      burst_left       = 0;
      hold_off_request = 1'b1;
      rnd              = $urandom;
      if (clear_first) paced_send(fsla_pkg::CMD_RESET, rnd[fsla_pkg::SLOT_W-1:0]);
      repeat (count) random_request(alloc_pct);
   endtask

   initial begin
      pool_tracker     = new();
      hold_off_request = 1'b0;
      pacing_on        = 1'b0;
      burst_left       = 0;
      idle_cycles      = 0;
      csr_errors       = 0;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = fsla_pkg::CMD_ALLOC;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = REG_SLOTS_IN_USE;
      csr_pwdata       = '0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_request(fsla_pkg::CMD_ALLOC, 8'h00);
      send_request(fsla_pkg::CMD_ALLOC, 8'hff);
      send_request(fsla_pkg::CMD_ALLOC, 8'hff);
      send_request(fsla_pkg::CMD_FREE, 8'd1);
      send_request(fsla_pkg::CMD_FREE, 8'd2);
      send_request(fsla_pkg::CMD_ALLOC, 8'h55);
      send_request(fsla_pkg::CMD_ALLOC, 8'haa);
      send_request(fsla_pkg::CMD_ALLOC, 8'h00);
      send_request(fsla_pkg::CMD_FREE, 8'd255);
      send_request(fsla_pkg::CMD_ALLOC, 8'h00);
      send_request(CMD_UNUSED, 8'haa);
      send_request(fsla_pkg::CMD_RESET, 8'h55);
      send_request(fsla_pkg::CMD_ALLOC, 8'h00);
      drain_results();
      write_pool_size(32'd2);
      send_request(fsla_pkg::CMD_ALLOC, 8'h00);
      send_request(fsla_pkg::CMD_ALLOC, 8'h00);
      send_request(fsla_pkg::CMD_FREE, 8'd2);
      send_request(fsla_pkg::CMD_FREE, 8'd255);
      send_request(fsla_pkg::CMD_FREE, 8'd0);
      send_request(fsla_pkg::CMD_ALLOC, 8'hff);
      send_request(fsla_pkg::CMD_ALLOC, 8'h00);
      send_request(fsla_pkg::CMD_FREE, 8'd1);
      send_request(fsla_pkg::CMD_FREE, 8'd0);
      send_request(fsla_pkg::CMD_ALLOC, 8'h00);
      send_request(fsla_pkg::CMD_ALLOC, 8'h00);

      run_phase(32'd256, 1'b1, 190, 90, 1'b1);
      run_phase(32'd1, 1'b1, 190, 50, 1'b0);
      run_phase(32'd2, 1'b0, 190, 60, 1'b1);
      run_phase(32'd0, 1'b1, 190, 50, 1'b1);
      run_phase(32'd511, 1'b0, 190, 40, 1'b0);
      run_phase($urandom_range(3, 24), 1'b1, 190, 55, 1'b1);
      run_phase(32'd300, 1'b1, 190, 70, 1'b1);
      run_phase(32'd5, 1'b0, 190, 50, 1'b1);
      run_phase($urandom_range(1, 511), 1'b1, 190, 50, 1'b0);
      run_phase(32'd256, 1'b0, 190, 45, 1'b1);

      drain_results();
      repeat (8) @(posedge clock);
      if (pool_tracker.errors == 0 && csr_errors == 0 &&
          pool_tracker.expected_grants.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
